>>> rtl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared constants, command codes and handshake structs for the frustum
// plane extraction block.
// ----------------------------------------------------------------------------
package fpe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 66;
    localparam int SQ_W      = 64;
    localparam int LEN_W     = 33;
    localparam int DIV_NW    = DATA_W + FRAC_BITS;
    localparam int IT_W      = $clog2(DIV_NW);
    localparam int SQRT_STEPS = 32;

    localparam logic [1:0] ACT_LOAD_VIEW = 2'd0;
    localparam logic [1:0] ACT_LOAD_PROJ = 2'd1;
    localparam logic [1:0] ACT_COMPUTE   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_V,
        OP_LOAD_P,
        OP_MUL,
        OP_ACC,
        OP_STORE,
        OP_LD3,
        OP_LDK,
        OP_SQ,
        OP_SQACC,
        OP_CHECK,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] e;
        logic [1:0] k;
        logic [1:0] i;
        logic [1:0] row;
        logic       minus;
        logic [2:0] plane;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic sq_zero;
        logic out_free;
    } status_t;

endpackage

>>> rtl/frustum_plane_extract.sv
// ----------------------------------------------------------------------------
// frustum_plane_extract
// View-projection frustum plane extraction in signed fixed point.
//
//   channel | valid / ready        | payload
//   input   | in_valid / in_ready  | action, element_index, element_value
//   output  | out_valid / out_ready| plane_id, normal_x/y/z, plane_offset,
//           |                      | degenerate, last_plane
//
// a load beat is written in its accept cycle; a compute beat, once accepted, runs
// the product (a multiply and an accumulate per term, a store per element), then
// per plane the coefficient loads, squares, zero check and emit, plus 32 root
// steps and 4 divides unless the normal is zero.
// the shared multiplier, root and one-bit-a-cycle divider set the compute time.
// reset clears both matrices to zero. the next plane is computed while the
// previous result beat waits; a stalled output only holds the sequencer at
// the point of emitting.
// ----------------------------------------------------------------------------
module frustum_plane_extract (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [3:0]           element_index,
    input  logic signed [31:0]   element_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           plane_id,
    output logic signed [31:0]   normal_x,
    output logic signed [31:0]   normal_y,
    output logic signed [31:0]   normal_z,
    output logic signed [31:0]   plane_offset,
    output logic                 degenerate,
    output logic                 last_plane
);

    fpe_pkg::cmd_t    cmd;
    fpe_pkg::status_t status;

    fpe_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .element_index (element_index),
        .status        (status),
        .cmd           (cmd)
    );

    fpe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .plane_id      (plane_id),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .plane_offset  (plane_offset),
        .degenerate    (degenerate),
        .last_plane    (last_plane)
    );

endmodule

>>> rtl/fpe_ctrl.sv
// ----------------------------------------------------------------------------
// fpe_ctrl
// Sequencer: walks the product, plane, root and divide loops and issues
// one datapath command per cycle, except while idle or while an emit waits on the output.
// ----------------------------------------------------------------------------
module fpe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [3:0]            element_index,
    input  fpe_pkg::status_t      status,
    output fpe_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_STORE, S_LD3, S_LDK, S_SQ, S_SQACC,
        S_CHECK, S_SQRT, S_DINIT, S_DIV, S_DFIN, S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [3:0]                  e_reg, e_next;
    logic [1:0]                  k_reg, k_next;
    logic [1:0]                  i_reg, i_next;
    logic [2:0]                  p_reg, p_next;
    logic [fpe_pkg::IT_W-1:0]    it_reg, it_next;
    logic                        accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        p_next     = p_reg;
        it_next    = it_reg;
        cmd        = '0;
        cmd.op     = fpe_pkg::OP_NONE;
        cmd.e      = e_reg;
        cmd.k      = k_reg;
        cmd.i      = i_reg;
        cmd.row    = p_reg[2:1];
        cmd.minus  = p_reg[0];
        cmd.plane  = p_reg;
        cmd.last   = (p_reg == 3'd5);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.e = element_index;
                    if (action == fpe_pkg::ACT_LOAD_VIEW)
                        cmd.op = fpe_pkg::OP_LOAD_V;
                    else if (action == fpe_pkg::ACT_LOAD_PROJ)
                        cmd.op = fpe_pkg::OP_LOAD_P;
                    else if (action == fpe_pkg::ACT_COMPUTE)
                    begin
                        e_next     = '0;
                        k_next     = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.op     = fpe_pkg::OP_MUL;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = fpe_pkg::OP_ACC;
                if (k_reg == 2'd3)
                    state_next = S_STORE;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_STORE:
            begin
                cmd.op = fpe_pkg::OP_STORE;
                k_next = '0;
                if (e_reg == 4'd15)
                begin
                    p_next     = '0;
                    i_next     = '0;
                    state_next = S_LD3;
                end
                else
                begin
                    e_next     = e_reg + 4'd1;
                    state_next = S_MUL;
                end
            end
            S_LD3:
            begin
                cmd.op     = fpe_pkg::OP_LD3;
                state_next = S_LDK;
            end
            S_LDK:
            begin
                cmd.op = fpe_pkg::OP_LDK;
                if (i_reg == 2'd3)
                begin
                    i_next     = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_LD3;
                end
            end
            S_SQ:
            begin
                cmd.op     = fpe_pkg::OP_SQ;
                state_next = S_SQACC;
            end
            S_SQACC:
            begin
                cmd.op = fpe_pkg::OP_SQACC;
                if (i_reg == 2'd2)
                    state_next = S_CHECK;
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_CHECK:
            begin
                cmd.op  = fpe_pkg::OP_CHECK;
                it_next = '0;
                state_next = status.sq_zero ? S_EMIT : S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op  = fpe_pkg::OP_SQRT_STEP;
                it_next = it_reg + 1'b1;
                if (it_reg == fpe_pkg::IT_W'(fpe_pkg::SQRT_STEPS - 1))
                begin
                    i_next     = '0;
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.op     = fpe_pkg::OP_DIV_INIT;
                it_next    = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op  = fpe_pkg::OP_DIV_STEP;
                it_next = it_reg + 1'b1;
                if (it_reg == fpe_pkg::IT_W'(fpe_pkg::DIV_NW - 1))
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                cmd.op = fpe_pkg::OP_DIV_DONE;
                if (i_reg == 2'd3)
                    state_next = S_EMIT;
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_DINIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = fpe_pkg::OP_EMIT;
                    i_next = '0;
                    if (p_reg == 3'd5)
                        state_next = S_IDLE;
                    else
                    begin
                        p_next     = p_reg + 3'd1;
                        state_next = S_LD3;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            e_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            p_reg     <= '0;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            p_reg     <= p_next;
            it_reg    <= it_next;
        end
    end

endmodule

>>> rtl/fpe_datapath.sv
// ----------------------------------------------------------------------------
// fpe_datapath
// Matrix stores, shared multiplier, root and divider units, and the result
// register of the output channel.
// ----------------------------------------------------------------------------
module fpe_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpe_pkg::cmd_t         cmd,
    output fpe_pkg::status_t      status,
    input  logic signed [31:0]    element_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            plane_id,
    output logic signed [31:0]    normal_x,
    output logic signed [31:0]    normal_y,
    output logic signed [31:0]    normal_z,
    output logic signed [31:0]    plane_offset,
    output logic                  degenerate,
    output logic                  last_plane
);

    localparam int F  = fpe_pkg::FRAC_BITS;
    localparam int NW = fpe_pkg::DIV_NW;
    localparam int LW = fpe_pkg::LEN_W;

    logic signed [31:0]             view_reg [16];
    logic signed [31:0]             proj_reg [16];
    logic signed [31:0]             prod_reg [16];
    logic signed [63:0]             mul_reg;
    logic signed [fpe_pkg::ACC_W-1:0] acc_reg;
    logic signed [31:0]             a_reg;
    logic signed [31:0]             co_reg [4];
    logic [63:0]                    sqp_reg;
    logic [63:0]                    sq_reg;
    logic [63:0]                    x_reg, res_reg, bit_reg;
    logic [NW-1:0]                  num_reg, q_reg;
    logic [LW:0]                    rem_reg;
    logic                           neg_reg;
    logic                           degen_reg;
    logic signed [31:0]             qout_reg [4];
    logic                           out_valid_reg;

    logic signed [31:0]             p_sel, v_sel, b_sel, co_sel;
    logic signed [fpe_pkg::ACC_W-1:0] rnd;
    logic signed [32:0]             coef;
    logic signed [31:0]             coef_sat, acc_sat;
    logic [63:0]                    trial_sqrt;
    logic [LW:0]                    trial_div;
    logic [31:0]                    mag;
    logic signed [31:0]             q_sat;

    localparam logic signed [fpe_pkg::ACC_W-1:0] HALF = fpe_pkg::ACC_W'(1) <<< (F - 1);
    localparam logic signed [fpe_pkg::ACC_W-1:0] AMAX = fpe_pkg::ACC_W'(32'sh7fff_ffff);
    localparam logic signed [fpe_pkg::ACC_W-1:0] AMIN = -(fpe_pkg::ACC_W'(33'sh0_8000_0000));

    always_comb
    begin
        p_sel  = proj_reg[{cmd.k, cmd.e[1:0]}];
        v_sel  = view_reg[{cmd.e[3:2], cmd.k}];
        b_sel  = prod_reg[{cmd.i, cmd.row}];
        co_sel = co_reg[cmd.i];

        rnd = (acc_reg + HALF) >>> F;
        if (rnd > AMAX)
            acc_sat = 32'sh7fff_ffff;
        else if (rnd < AMIN)
            acc_sat = 32'sh8000_0000;
        else
            acc_sat = rnd[31:0];

        coef = cmd.minus ? (33'(a_reg) - 33'(b_sel)) : (33'(a_reg) + 33'(b_sel));
        if (coef[32] != coef[31])
            coef_sat = coef[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            coef_sat = coef[31:0];

        trial_sqrt = res_reg + bit_reg;
        trial_div  = {rem_reg[LW-1:0], num_reg[NW-1]};
        mag        = co_sel[31] ? (32'd0 - co_sel) : co_sel;

        if (neg_reg)
            q_sat = (q_reg > NW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                          : (32'd0 - q_reg[31:0]);
        else
            q_sat = (q_reg > NW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : q_reg[31:0];
    end

    // matrix stores reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 16; n++)
            begin
                view_reg[n] <= '0;
                proj_reg[n] <= '0;
            end
        end
        else
        begin
            if (cmd.op == fpe_pkg::OP_LOAD_V)
                view_reg[cmd.e] <= element_value;
            if (cmd.op == fpe_pkg::OP_LOAD_P)
                proj_reg[cmd.e] <= element_value;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            fpe_pkg::OP_MUL:
                mul_reg <= p_sel * v_sel;
            fpe_pkg::OP_ACC:
                acc_reg <= (cmd.k == 2'd0) ? fpe_pkg::ACC_W'(mul_reg)
                                          : acc_reg + fpe_pkg::ACC_W'(mul_reg);
            fpe_pkg::OP_STORE:
                prod_reg[cmd.e] <= acc_sat;
            fpe_pkg::OP_LD3:
                a_reg <= prod_reg[{cmd.i, 2'd3}];
            fpe_pkg::OP_LDK:
                co_reg[cmd.i] <= coef_sat;
            fpe_pkg::OP_SQ:
                sqp_reg <= 64'(co_sel * co_sel);
            fpe_pkg::OP_SQACC:
                sq_reg <= (cmd.i == 2'd0) ? sqp_reg : sq_reg + sqp_reg;
            fpe_pkg::OP_CHECK:
            begin
                x_reg   <= sq_reg;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            fpe_pkg::OP_SQRT_STEP:
            begin
                if (x_reg >= trial_sqrt)
                begin
                    x_reg   <= x_reg - trial_sqrt;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            fpe_pkg::OP_DIV_INIT:
            begin
                num_reg <= NW'(mag) << F;
                neg_reg <= co_sel[31];
                rem_reg <= '0;
                q_reg   <= '0;
            end
            fpe_pkg::OP_DIV_STEP:
            begin
                num_reg <= num_reg << 1;
                if (trial_div >= {1'b0, res_reg[LW-1:0]})
                begin
                    rem_reg <= trial_div - {1'b0, res_reg[LW-1:0]};
                    q_reg   <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial_div;
                    q_reg   <= {q_reg[NW-2:0], 1'b0};
                end
            end
            fpe_pkg::OP_DIV_DONE:
                qout_reg[cmd.i] <= q_sat;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degen_reg <= 1'b0;
        else if (cmd.op == fpe_pkg::OP_CHECK)
            degen_reg <= (sq_reg == 64'd0);
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == fpe_pkg::OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == fpe_pkg::OP_EMIT)
        begin
            plane_id     <= cmd.plane;
            last_plane   <= cmd.last;
            degenerate   <= degen_reg;
            normal_x     <= degen_reg ? '0 : qout_reg[0];
            normal_y     <= degen_reg ? '0 : qout_reg[1];
            normal_z     <= degen_reg ? '0 : qout_reg[2];
            plane_offset <= degen_reg ? '0 : qout_reg[3];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.sq_zero  = (sq_reg == 64'd0);
    assign status.out_free = !out_valid_reg || out_ready;

endmodule
